[rtl/core/rmec_pkg.sv]
// shared types, constants and arithmetic helpers for the euler / rotation matrix converter
// no dependencies
package rmec_pkg;

   localparam int SQRT_STAGES = 16;
   localparam int ATAN_LEN    = 32;
   localparam int THR_W       = 11;

   localparam logic signed [32:0] ONE_GAIN = 33'sd652032874;

   // transaction modes
   localparam logic MODE_TO_ANGLES = 1'b0;
   localparam logic MODE_TO_MATRIX = 1'b1;

   typedef struct packed {
      logic               mode;
      logic signed [15:0] m00_in;
      logic signed [15:0] m10_in;
      logic signed [15:0] m11_in;
      logic signed [15:0] m12_in;
      logic signed [15:0] m20_in;
      logic signed [15:0] m21_in;
      logic signed [15:0] m22_in;
      logic signed [15:0] roll_in;
      logic signed [15:0] pitch_in;
      logic signed [15:0] yaw_in;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] roll_out;
      logic signed [15:0] pitch_out;
      logic signed [15:0] yaw_out;
      logic signed [15:0] r00_out;
      logic signed [15:0] r01_out;
      logic signed [15:0] r02_out;
      logic signed [15:0] r10_out;
      logic signed [15:0] r11_out;
      logic signed [15:0] r12_out;
      logic signed [15:0] r20_out;
      logic signed [15:0] r21_out;
      logic signed [15:0] r22_out;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
   } mat_type;

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
      logic signed [15:0] yaw;
   } ang_type;

   typedef struct packed {
      logic signed [32:0] sx;
      logic signed [32:0] cx;
      logic signed [32:0] sy;
      logic signed [32:0] cy;
      logic signed [32:0] sz;
      logic signed [32:0] cz;
   } trig_type;

   // atan(2^-i) as a 32 bit binary angle, one turn = 2^32
   function automatic logic [31:0] atan_angle(input int idx);
      logic [31:0] a;
      case (idx)
         0:  a = 32'd536870912;
         1:  a = 32'd316933406;
         2:  a = 32'd167458907;
         3:  a = 32'd85004756;
         4:  a = 32'd42667331;
         5:  a = 32'd21354465;
         6:  a = 32'd10679838;
         7:  a = 32'd5340245;
         8:  a = 32'd2670163;
         9:  a = 32'd1335087;
         10: a = 32'd667544;
         11: a = 32'd333772;
         12: a = 32'd166886;
         13: a = 32'd83443;
         14: a = 32'd41722;
         15: a = 32'd20861;
         16: a = 32'd10430;
         17: a = 32'd5215;
         18: a = 32'd2608;
         19: a = 32'd1304;
         20: a = 32'd652;
         21: a = 32'd326;
         22: a = 32'd163;
         23: a = 32'd81;
         24: a = 32'd41;
         25: a = 32'd20;
         26: a = 32'd10;
         27: a = 32'd5;
         28: a = 32'd3;
         29: a = 32'd1;
         30: a = 32'd1;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

   // product at scale 2^30, rounded half up
   function automatic logic signed [32:0] mul30(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
      logic signed [65:0] p;
      p = 66'(a) * 66'(b) + (66'sd1 <<< 29);
      return p[62:30];
   endfunction

endpackage

[rtl/core/rmec_req_if.sv]
// request channel of the converter: valid / ready plus the input item
// depends on rmec_pkg
interface rmec_req_if;
   logic                     valid;
   logic                     ready;
   rmec_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/rmec_rsp_if.sv]
// response channel of the converter: valid / ready plus the result item
// depends on rmec_pkg
interface rmec_rsp_if;
   logic                     valid;
   logic                     ready;
   rmec_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/rmec_delay.sv]
// enabled shift line that carries payload alongside the pipeline
// no dependencies
module rmec_delay #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d_in,
   output logic [WIDTH-1:0] d_out
);
   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= d_in;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign d_out = tap_ff[DEPTH-1];
endmodule

[rtl/core/rmec_isqrt.sv]
// pipelined integer square root, one result bit per stage
// depends on rmec_pkg
module rmec_isqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] n_in,
   output logic [15:0] root
);
   localparam int N = rmec_pkg::SQRT_STAGES;

   logic [31:0] rem_ff  [N+1];
   logic [31:0] root_ff [N+1];

   assign rem_ff[0]  = n_in;
   assign root_ff[0] = '0;

   for (genvar k = 0; k < N; k++) begin : g_stage
      localparam logic [31:0] BIT = 32'd1 << (30 - 2*k);
      logic [31:0] cand;
      assign cand = root_ff[k] + BIT;
      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_ff[k] >= cand) begin
               rem_ff[k+1]  <= rem_ff[k] - cand;
               root_ff[k+1] <= (root_ff[k] >> 1) + BIT;
            end else begin
               rem_ff[k+1]  <= rem_ff[k];
               root_ff[k+1] <= root_ff[k] >> 1;
            end
         end
      end
   end

   assign root = root_ff[N][15:0];
endmodule

[rtl/core/rmec_vec_cordic.sv]
// pipelined vectoring cordic giving atan2(y, x) as a 16 bit binary angle
// depends on rmec_pkg
module rmec_vec_cordic #(
   parameter int STAGES = 16
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [16:0] y_in,
   input  logic signed [16:0] x_in,
   output logic signed [15:0] angle
);
   logic signed [33:0] x_ff [STAGES+1];
   logic signed [33:0] y_ff [STAGES+1];
   logic [31:0]        acc_ff [STAGES+1];
   logic               zero_ff [STAGES+1];

   logic signed [33:0] xs, ys;
   logic [31:0]        acc_sum;

   assign xs = 34'(x_in) <<< 14;
   assign ys = 34'(y_in) <<< 14;

   // fold into the right half plane
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
         if (x_in < 0) begin
            x_ff[0]   <= -xs;
            y_ff[0]   <= -ys;
            acc_ff[0] <= 32'h8000_0000;
         end else begin
            x_ff[0]   <= xs;
            y_ff[0]   <= ys;
            acc_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam logic [31:0] ANG = rmec_pkg::atan_angle(i);
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1]   <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1]   <= y_ff[i] - (x_ff[i] >>> i);
               acc_ff[i+1] <= acc_ff[i] + ANG;
            end else begin
               x_ff[i+1]   <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1]   <= y_ff[i] + (x_ff[i] >>> i);
               acc_ff[i+1] <= acc_ff[i] - ANG;
            end
         end
      end
   end

   assign acc_sum = acc_ff[STAGES] + 32'h0000_8000;
   assign angle   = zero_ff[STAGES] ? 16'sd0 : acc_sum[31:16];
endmodule

[rtl/core/rmec_rot_cordic.sv]
// pipelined rotation cordic giving sine and cosine at scale 2^30
// depends on rmec_pkg
module rmec_rot_cordic #(
   parameter int STAGES = 16
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [15:0] ang_in,
   output logic signed [32:0] sin_out,
   output logic signed [32:0] cos_out
);
   logic signed [32:0] x_ff [STAGES+1];
   logic signed [32:0] y_ff [STAGES+1];
   logic signed [33:0] z_ff [STAGES+1];
   logic               flip_ff [STAGES+1];

   logic signed [33:0] z0;
   assign z0 = 34'(ang_in) <<< 16;

   // move into [-pi/2, pi/2], negating the results later
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= rmec_pkg::ONE_GAIN;
         y_ff[0] <= '0;
         if (z0 > 34'sd1073741824) begin
            z_ff[0]    <= z0 - 34'sd2147483648;
            flip_ff[0] <= 1'b1;
         end else if (z0 < -34'sd1073741824) begin
            z_ff[0]    <= z0 + 34'sd2147483648;
            flip_ff[0] <= 1'b1;
         end else begin
            z_ff[0]    <= z0;
            flip_ff[0] <= 1'b0;
         end
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam logic signed [33:0] ANG = 34'(rmec_pkg::atan_angle(i));
      always_ff @(posedge clock) begin
         if (en) begin
            flip_ff[i+1] <= flip_ff[i];
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ANG;
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ANG;
            end
         end
      end
   end

   assign sin_out = flip_ff[STAGES] ? -y_ff[STAGES] : y_ff[STAGES];
   assign cos_out = flip_ff[STAGES] ? -x_ff[STAGES] : x_ff[STAGES];
endmodule

[rtl/core/rmec_mat_build.sv]
// three stage product tree building rz*ry*rx from sines and cosines
// depends on rmec_pkg
module rmec_mat_build #(
   parameter int FRAC_BITS = 14
) (
   input  logic                   clock,
   input  logic                   en,
   input  rmec_pkg::trig_type     trig,
   output logic signed [15:0]     ent_out [9]
);
   localparam int SH = 30 - FRAC_BITS;
   localparam logic signed [35:0] HALF = (SH > 0) ? (36'sd1 <<< (SH - 1)) : 36'sd0;

   function automatic logic signed [15:0] to_entry(input logic signed [34:0] v);
      logic signed [35:0] w;
      w = 36'(v) + HALF;
      w = w >>> SH;
      if (w > 36'sd32767)       return 16'sh7fff;
      else if (w < -36'sd32768) return 16'sh8000;
      else                      return w[15:0];
   endfunction

   // first products
   logic signed [32:0] czsy_ff, szsy_ff, czcy_ff, szcx_ff, szcy_ff, szsx_ff;
   logic signed [32:0] czcx_ff, cysx_ff, cycx_ff, czsx_ff, sxa_ff, cxa_ff, sya_ff;
   // second products
   logic signed [32:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [32:0] czcy_b_ff, szcx_b_ff, szcy_b_ff, czcx_b_ff, czsx_b_ff, szsx_b_ff;
   logic signed [32:0] cysx_b_ff, cycx_b_ff, syb_ff;
   logic signed [15:0] ent_ff [9];

   always_ff @(posedge clock) begin
      if (en) begin
         czsy_ff <= rmec_pkg::mul30(trig.cz, trig.sy);
         szsy_ff <= rmec_pkg::mul30(trig.sz, trig.sy);
         czcy_ff <= rmec_pkg::mul30(trig.cz, trig.cy);
         szcx_ff <= rmec_pkg::mul30(trig.sz, trig.cx);
         szcy_ff <= rmec_pkg::mul30(trig.sz, trig.cy);
         szsx_ff <= rmec_pkg::mul30(trig.sz, trig.sx);
         czcx_ff <= rmec_pkg::mul30(trig.cz, trig.cx);
         cysx_ff <= rmec_pkg::mul30(trig.cy, trig.sx);
         cycx_ff <= rmec_pkg::mul30(trig.cy, trig.cx);
         czsx_ff <= rmec_pkg::mul30(trig.cz, trig.sx);
         sxa_ff  <= trig.sx;
         cxa_ff  <= trig.cx;
         sya_ff  <= trig.sy;

         p1_ff     <= rmec_pkg::mul30(czsy_ff, sxa_ff);
         p2_ff     <= rmec_pkg::mul30(czsy_ff, cxa_ff);
         p3_ff     <= rmec_pkg::mul30(szsy_ff, sxa_ff);
         p4_ff     <= rmec_pkg::mul30(szsy_ff, cxa_ff);
         czcy_b_ff <= czcy_ff;
         szcx_b_ff <= szcx_ff;
         szcy_b_ff <= szcy_ff;
         szsx_b_ff <= szsx_ff;
         czcx_b_ff <= czcx_ff;
         czsx_b_ff <= czsx_ff;
         cysx_b_ff <= cysx_ff;
         cycx_b_ff <= cycx_ff;
         syb_ff    <= sya_ff;

         ent_ff[0] <= to_entry(35'(czcy_b_ff));
         ent_ff[1] <= to_entry(35'(p1_ff) - 35'(szcx_b_ff));
         ent_ff[2] <= to_entry(35'(p2_ff) + 35'(szsx_b_ff));
         ent_ff[3] <= to_entry(35'(szcy_b_ff));
         ent_ff[4] <= to_entry(35'(p3_ff) + 35'(czcx_b_ff));
         ent_ff[5] <= to_entry(35'(p4_ff) - 35'(czsx_b_ff));
         ent_ff[6] <= to_entry(-35'(syb_ff));
         ent_ff[7] <= to_entry(35'(cysx_b_ff));
         ent_ff[8] <= to_entry(35'(cycx_b_ff));
      end
   end

   assign ent_out = ent_ff;
endmodule

[rtl/core/rotation_matrix_euler_convert_unit.sv]
// throughput: one transaction per cycle, set by the fully pipelined cordic, square root
//   and multiplier stages; a stalled response holds the whole pipeline in place
// reset: synchronous, active high; clears the valid bits and sets the singular threshold to 1
// depends on rmec_pkg, rmec_req_if, rmec_rsp_if and the rmec_* datapath modules
module rotation_matrix_euler_convert_unit #(
   parameter int FRAC_BITS     = 14,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   rmec_req_if.sink                     req_chan,
   rmec_rsp_if.source                   rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [rmec_pkg::THR_W-1:0]   csr_wr_data
);
   // pipeline depth: squares, sum, square root, operand select, cordic pre-stage,
   // cordic stages, output register
   localparam int LAT     = CORDIC_STAGES + 2 + rmec_pkg::SQRT_STAGES + 3;
   // angle path: pre-stage, cordic stages, three product stages, output register
   localparam int ANG_DLY = LAT - (CORDIC_STAGES + 5);

   // singular threshold register
   logic [rmec_pkg::THR_W-1:0] thr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= rmec_pkg::THR_W'(1);
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // the whole pipeline moves unless a finished result is waiting
   logic en;
   logic take;
   assign en   = !rsp_chan.valid || rsp_chan.ready;
   assign take = req_chan.valid && en;
   assign req_chan.ready = en;

   // valid bits travel with the data
   logic [LAT-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], take};
      end
   end

   rmec_pkg::req_payload_type req;
   assign req = req_chan.payload;

   // ---- matrix to angles path ----
   // squares of the first column entries
   logic [31:0] sq0_ff, sq1_ff, sum_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         sq0_ff <= 32'(req.m00_in * req.m00_in);
         sq1_ff <= 32'(req.m10_in * req.m10_in);
         sum_ff <= sq0_ff + sq1_ff;
      end
   end

   logic [15:0] sy;
   rmec_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .n_in  (sum_ff),
      .root  (sy)
   );

   // matrix entries ride alongside the squares and the root
   rmec_pkg::mat_type mat_in, mat_d;
   assign mat_in = '{m00: req.m00_in, m10: req.m10_in, m11: req.m11_in, m12: req.m12_in,
                     m20: req.m20_in, m21: req.m21_in, m22: req.m22_in};

   rmec_delay #(
      .WIDTH ($bits(rmec_pkg::mat_type)),
      .DEPTH (2 + rmec_pkg::SQRT_STAGES)
   ) u_mat_dly (
      .clock (clock),
      .en    (en),
      .d_in  (mat_in),
      .d_out (mat_d)
   );

   // gimbal lock decision and atan2 operand select
   logic               singular;
   logic signed [16:0] roll_y_ff, roll_x_ff, pitch_y_ff, pitch_x_ff, yaw_y_ff, yaw_x_ff;
   assign singular = (sy < 16'(thr_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         pitch_y_ff <= -17'(mat_d.m20);
         pitch_x_ff <= {1'b0, sy};
         if (singular) begin
            roll_y_ff <= -17'(mat_d.m12);
            roll_x_ff <= 17'(mat_d.m11);
            // atan2(0,0) gives the zero yaw of the singular case
            yaw_y_ff  <= '0;
            yaw_x_ff  <= '0;
         end else begin
            roll_y_ff <= 17'(mat_d.m21);
            roll_x_ff <= 17'(mat_d.m22);
            yaw_y_ff  <= 17'(mat_d.m10);
            yaw_x_ff  <= 17'(mat_d.m00);
         end
      end
   end

   logic signed [15:0] roll_a, pitch_a, yaw_a;

   rmec_vec_cordic #(.STAGES(CORDIC_STAGES)) u_roll_atan (
      .clock (clock), .en (en), .y_in (roll_y_ff), .x_in (roll_x_ff), .angle (roll_a)
   );
   rmec_vec_cordic #(.STAGES(CORDIC_STAGES)) u_pitch_atan (
      .clock (clock), .en (en), .y_in (pitch_y_ff), .x_in (pitch_x_ff), .angle (pitch_a)
   );
   rmec_vec_cordic #(.STAGES(CORDIC_STAGES)) u_yaw_atan (
      .clock (clock), .en (en), .y_in (yaw_y_ff), .x_in (yaw_x_ff), .angle (yaw_a)
   );

   // ---- angles to matrix path ----
   // angles wait so that both paths finish together
   rmec_pkg::ang_type ang_in, ang_d;
   assign ang_in = '{roll: req.roll_in, pitch: req.pitch_in, yaw: req.yaw_in};

   rmec_delay #(
      .WIDTH ($bits(rmec_pkg::ang_type)),
      .DEPTH (ANG_DLY)
   ) u_ang_dly (
      .clock (clock),
      .en    (en),
      .d_in  (ang_in),
      .d_out (ang_d)
   );

   rmec_pkg::trig_type trig;

   rmec_rot_cordic #(.STAGES(CORDIC_STAGES)) u_roll_sc (
      .clock (clock), .en (en), .ang_in (ang_d.roll), .sin_out (trig.sx), .cos_out (trig.cx)
   );
   rmec_rot_cordic #(.STAGES(CORDIC_STAGES)) u_pitch_sc (
      .clock (clock), .en (en), .ang_in (ang_d.pitch), .sin_out (trig.sy), .cos_out (trig.cy)
   );
   rmec_rot_cordic #(.STAGES(CORDIC_STAGES)) u_yaw_sc (
      .clock (clock), .en (en), .ang_in (ang_d.yaw), .sin_out (trig.sz), .cos_out (trig.cz)
   );

   logic signed [15:0] ent [9];
   rmec_mat_build #(.FRAC_BITS(FRAC_BITS)) u_mat (
      .clock   (clock),
      .en      (en),
      .trig    (trig),
      .ent_out (ent)
   );

   // mode follows the item to the output register
   logic mode_d;
   rmec_delay #(
      .WIDTH (1),
      .DEPTH (LAT - 1)
   ) u_mode_dly (
      .clock (clock),
      .en    (en),
      .d_in  (req.mode),
      .d_out (mode_d)
   );

   // ---- output register, unused fields zero ----
   rmec_pkg::rsp_payload_type out_in, out_ff;
   always_comb begin
      out_in = '0;
      if (mode_d == rmec_pkg::MODE_TO_MATRIX) begin
         out_in.r00_out = ent[0];
         out_in.r01_out = ent[1];
         out_in.r02_out = ent[2];
         out_in.r10_out = ent[3];
         out_in.r11_out = ent[4];
         out_in.r12_out = ent[5];
         out_in.r20_out = ent[6];
         out_in.r21_out = ent[7];
         out_in.r22_out = ent[8];
      end else begin
         out_in.roll_out  = roll_a;
         out_in.pitch_out = pitch_a;
         out_in.yaw_out   = yaw_a;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid   = vld_ff[LAT-1];
   assign rsp_chan.payload = out_ff;
endmodule

[tb/rotation_matrix_euler_convert_unit_tb.sv]
// self-checking testbench for the euler angle / rotation matrix converter
// drives random and directed transactions through both modes and checks every response
// depends on rmec_pkg, rmec_req_if, rmec_rsp_if and rotation_matrix_euler_convert_unit
`timescale 1ns / 100ps

module rotation_matrix_euler_convert_unit_tb;

   localparam int HALF_PERIOD = 10;
   localparam int STAGES      = 16;
   localparam int LATENCY     = STAGES + 21;
   localparam int IDLE_LIMIT  = 2000;

   // atan(2^-i) in a 32 bit binary angle, one turn = 2^32
   localparam longint ATAN_STEP [0:15] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
      5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [rmec_pkg::THR_W-1:0] csr_wr_data = '0;

   rmec_req_if req_chan ();
   rmec_rsp_if rsp_chan ();

   rotation_matrix_euler_convert_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   rmec_pkg::req_payload_type pending_reqs[$];
   rmec_pkg::rsp_payload_type expected_rsps[$];
   logic [rmec_pkg::THR_W-1:0] thresh_copy = rmec_pkg::THR_W'(1);
   logic req_taken = 1'b0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_cycles = 0;
   int error_count = 0;
   int accepted_reqs = 0;
   int checked_rsps = 0;
   int idle_cycles = 0;

   // floor shift that works on negative values
   function automatic longint shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint int_sqrt(longint n);
      longint res, bit_v;
      res = 0;
      bit_v = 64'sd1 << 62;
      while (bit_v > n) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (n >= res + bit_v) begin
            n = n - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // vectoring cordic, result is a 16 bit binary angle
   function automatic logic signed [15:0] angle_of(longint yv, longint xv);
      longint x, y, nx;
      logic [31:0] acc, rounded;
      x = xv * 16384;
      y = yv * 16384;
      acc = '0;
      if (x == 0 && y == 0) return '0;
      if (x < 0) begin
         x = -x;
         y = -y;
         acc = 32'h8000_0000;
      end
      for (int i = 0; i < STAGES; i++) begin
         if (y >= 0) begin
            nx = x + shr(y, i);
            y = y - shr(x, i);
            acc = acc + 32'(ATAN_STEP[i]);
         end else begin
            nx = x - shr(y, i);
            y = y + shr(x, i);
            acc = acc - 32'(ATAN_STEP[i]);
         end
         x = nx;
      end
      rounded = acc + 32'h8000;
      return rounded[31:16];
   endfunction

   // rotation cordic giving sine and cosine at scale 2^30
   function automatic void sine_cosine(logic signed [15:0] ang, output longint s,
                                       output longint c);
      longint z, x, y, nx;
      bit flip;
      z = longint'(ang) * 65536;
      x = 652032874;
      y = 0;
      flip = 1'b0;
      if (z > 64'sd1073741824) begin
         z = z - 64'sd2147483648;
         flip = 1'b1;
      end else if (z < -64'sd1073741824) begin
         z = z + 64'sd2147483648;
         flip = 1'b1;
      end
      for (int i = 0; i < STAGES; i++) begin
         if (z >= 0) begin
            nx = x - shr(y, i);
            y = y + shr(x, i);
            z = z - ATAN_STEP[i];
         end else begin
            nx = x + shr(y, i);
            y = y - shr(x, i);
            z = z + ATAN_STEP[i];
         end
         x = nx;
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   function automatic longint prod30(longint a, longint b);
      return shr(a * b + (64'sd1 <<< 29), 30);
   endfunction

   function automatic logic signed [15:0] to_q14(longint v);
      v = shr(v + (64'sd1 <<< 15), 16);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
   endfunction

   function automatic rmec_pkg::rsp_payload_type convert_item(rmec_pkg::req_payload_type r);
      rmec_pkg::rsp_payload_type e;
      longint sy_len, sx, cx, sy, cy, sz, cz, czsy, szsy;
      e = '0;
      if (r.mode == rmec_pkg::MODE_TO_ANGLES) begin
         sy_len = int_sqrt(longint'(r.m00_in) * r.m00_in + longint'(r.m10_in) * r.m10_in);
         if (sy_len >= longint'(thresh_copy)) begin
            e.roll_out = angle_of(r.m21_in, r.m22_in);
            e.yaw_out  = angle_of(r.m10_in, r.m00_in);
         end else begin
            // gimbal lock: roll from the middle row, yaw forced to zero
            e.roll_out = angle_of(-longint'(r.m12_in), r.m11_in);
         end
         e.pitch_out = angle_of(-longint'(r.m20_in), sy_len);
      end else begin
         sine_cosine(r.roll_in, sx, cx);
         sine_cosine(r.pitch_in, sy, cy);
         sine_cosine(r.yaw_in, sz, cz);
         czsy = prod30(cz, sy);
         szsy = prod30(sz, sy);
         e.r00_out = to_q14(prod30(cz, cy));
         e.r01_out = to_q14(prod30(czsy, sx) - prod30(sz, cx));
         e.r02_out = to_q14(prod30(czsy, cx) + prod30(sz, sx));
         e.r10_out = to_q14(prod30(sz, cy));
         e.r11_out = to_q14(prod30(szsy, sx) + prod30(cz, cx));
         e.r12_out = to_q14(prod30(szsy, cx) - prod30(cz, sx));
         e.r20_out = to_q14(-sy);
         e.r21_out = to_q14(prod30(cy, sx));
         e.r22_out = to_q14(prod30(cy, cx));
      end
      return e;
   endfunction

   function automatic void check_field(string name, logic signed [15:0] exp_v,
                                       logic signed [15:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         error_count++;
      end
   endfunction

   // request acceptance as seen at the rising edge, used by the driver
   always @(posedge clock) begin
      req_taken <= req_chan.valid && req_chan.ready;
   end

   // driver: one item offered at a time, changes on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.payload <= '0;
      end else if (!req_chan.valid || req_taken) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_chan.valid <= 1'b1;
            req_chan.payload <= pending_reqs.pop_front();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure, with an optional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor: predict on accepted requests, check on accepted responses
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (req_chan.valid && req_chan.ready) begin
            expected_rsps.push_back(convert_item(req_chan.payload));
            accepted_reqs <= accepted_reqs + 1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            checked_rsps <= checked_rsps + 1;
            if (expected_rsps.size() == 0) begin
               $error("response transaction with nothing expected");
               error_count++;
            end else begin
               rmec_pkg::rsp_payload_type e, a;
               e = expected_rsps.pop_front();
               a = rsp_chan.payload;
               check_field("roll_out", e.roll_out, a.roll_out);
               check_field("pitch_out", e.pitch_out, a.pitch_out);
               check_field("yaw_out", e.yaw_out, a.yaw_out);
               check_field("r00_out", e.r00_out, a.r00_out);
               check_field("r01_out", e.r01_out, a.r01_out);
               check_field("r02_out", e.r02_out, a.r02_out);
               check_field("r10_out", e.r10_out, a.r10_out);
               check_field("r11_out", e.r11_out, a.r11_out);
               check_field("r12_out", e.r12_out, a.r12_out);
               check_field("r20_out", e.r20_out, a.r20_out);
               check_field("r21_out", e.r21_out, a.r21_out);
               check_field("r22_out", e.r22_out, a.r22_out);
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic signed [15:0] rand_word();
      case ($urandom_range(5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'(int'($urandom_range(16384)) - 8192) <<< 1;
         default: return 16'($urandom);
      endcase
   endfunction

   // mostly plausible rotation matrices built from angles, plus noise
   function automatic rmec_pkg::req_payload_type random_item(bit lockish);
      rmec_pkg::req_payload_type r;
      longint s1, c1, s2, c2, s3, c3;
      r = '0;
      r.mode = 1'($urandom_range(1));
      if ($urandom_range(3) != 0) begin
         sine_cosine(16'($urandom), s1, c1);
         sine_cosine(lockish ? 16'sh4000 + 16'($urandom_range(8)) - 16'sd4 : 16'($urandom),
                     s2, c2);
         sine_cosine(16'($urandom), s3, c3);
         r.m00_in = to_q14(prod30(c3, c2));
         r.m10_in = to_q14(prod30(s3, c2));
         r.m20_in = to_q14(-s2);
         r.m21_in = to_q14(prod30(c2, s1));
         r.m22_in = to_q14(prod30(c2, c1));
         r.m11_in = to_q14(prod30(c3, c1));
         r.m12_in = to_q14(-prod30(c3, s1));
      end else begin
         r.m00_in = rand_word();
         r.m10_in = rand_word();
         r.m11_in = rand_word();
         r.m12_in = rand_word();
         r.m20_in = rand_word();
         r.m21_in = rand_word();
         r.m22_in = rand_word();
      end
      r.roll_in = rand_word();
      r.pitch_in = rand_word();
      r.yaw_in = rand_word();
      return r;
   endfunction

   function automatic rmec_pkg::req_payload_type mat_item(logic signed [15:0] a,
                                                          logic signed [15:0] b);
      rmec_pkg::req_payload_type r;
      r = '0;
      r.mode = rmec_pkg::MODE_TO_ANGLES;
      r.m00_in = a;
      r.m10_in = b;
      r.m11_in = 16'sd16384;
      r.m12_in = b;
      r.m20_in = -a;
      r.m21_in = a;
      r.m22_in = b;
      return r;
   endfunction

   function automatic rmec_pkg::req_payload_type ang_item(logic signed [15:0] a,
                                                          logic signed [15:0] b,
                                                          logic signed [15:0] c);
      rmec_pkg::req_payload_type r;
      r = '0;
      r.mode = rmec_pkg::MODE_TO_MATRIX;
      r.roll_in = a;
      r.pitch_in = b;
      r.yaw_in = c;
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_chan.valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // register writes happen only with the pipeline empty
   task automatic write_threshold(logic [rmec_pkg::THR_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      thresh_copy = value;
   endtask

   task automatic random_phase(int count, int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < count; i++)
         pending_reqs.push_back(random_item($urandom_range(7) == 0));
      wait_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, both modes, zero vector and gimbal lock
      pending_reqs.push_back(mat_item(16'sd0, 16'sd0));
      pending_reqs.push_back(mat_item(16'sh7fff, 16'sh7fff));
      pending_reqs.push_back(mat_item(16'sh8000, 16'sh8000));
      pending_reqs.push_back(mat_item(16'sh8000, 16'sh7fff));
      pending_reqs.push_back(mat_item(16'sd16384, 16'sd0));
      pending_reqs.push_back(mat_item(-16'sd16384, 16'sd0));
      pending_reqs.push_back(mat_item(16'sd0, -16'sd1));
      pending_reqs.push_back(mat_item(16'sd1, 16'sd0));
      pending_reqs.push_back(mat_item(16'sd0, 16'sd1));
      pending_reqs.push_back(ang_item(16'sd0, 16'sd0, 16'sd0));
      pending_reqs.push_back(ang_item(16'sh7fff, 16'sh7fff, 16'sh7fff));
      pending_reqs.push_back(ang_item(16'sh8000, 16'sh8000, 16'sh8000));
      pending_reqs.push_back(ang_item(16'sh4000, 16'shc000, 16'sh4001));
      pending_reqs.push_back(ang_item(16'sh3fff, 16'sh4000, 16'shbfff));
      pending_reqs.push_back(ang_item(16'sh2000, 16'sh1555, 16'sh6aaa));
      wait_drained();

      // threshold at 1024, then the full 11 bit value
      write_threshold(11'd1024);
      pending_reqs.push_back(mat_item(16'sd1023, 16'sd0));
      pending_reqs.push_back(mat_item(16'sd1024, 16'sd0));
      pending_reqs.push_back(mat_item(16'sd0, -16'sd1025));
      wait_drained();
      write_threshold(11'h7ff);
      pending_reqs.push_back(mat_item(16'sd2046, 16'sd0));
      pending_reqs.push_back(mat_item(16'sd2047, 16'sd0));
      wait_drained();

      // long receiver hold-off so the pipeline fills and stalls its input
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_cycles = 3 * LATENCY;
      for (int i = 0; i < 120; i++) pending_reqs.push_back(random_item(1'b0));
      wait_drained();

      write_threshold(11'd0);
      random_phase(250, 27, 62);
      write_threshold(11'd1);
      random_phase(250, 62, 27);
      write_threshold(rmec_pkg::THR_W'($urandom_range(1024)));
      random_phase(330, 0, 0);

      $display("covered %0d requests and %0d checked responses in both modes,",
               accepted_reqs, checked_rsps);
      $display("threshold settings 0, 1, 1024, 2047 and random, with stalls on both sides");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
